FILE: rtl/tfcc_pkg.sv
`default_nettype none

package tfcc_pkg;

    localparam logic [15:0] CRC_POLY   = 16'h8005;
    localparam logic [7:0]  SPACE_CHAR = 8'h20;
    localparam logic [7:0]  MINUS_CHAR = 8'h2D;
    localparam logic [7:0]  PLUS_CHAR  = 8'h2B;
    localparam logic [7:0]  ZERO_CHAR  = 8'h30;
    localparam logic [7:0]  NINE_CHAR  = 8'h39;

    typedef enum logic [2:0] {
        PH_LEAD = 3'b001,   // before the first token
        PH_NUM  = 3'b010,   // inside the first token
        PH_BODY = 3'b100    // payload words
    } phase_t;

    // line totals handed from the parser to the result stage
    typedef struct packed {
        logic [31:0] acc;
        logic        minus;
        logic [15:0] crc;
    } tally_t;

    // MSB-first CRC-16 over one byte, eight unrolled shift/xor steps
    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] data);
        logic [15:0] c;
        logic        fb;
        c = crc_in;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[15] ^ data[i];
            c  = {c[14:0], 1'b0};
            if (fb)
            begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/tfcc_parser.sv
`default_nettype none

module tfcc_parser (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic [7:0]      char_byte,
    input  wire logic            last_char,
    output logic                 tally_valid,
    input  wire logic            tally_ready,
    output tfcc_pkg::tally_t     tally
);
    import tfcc_pkg::*;

    logic        hold_valid_reg;
    logic [7:0]  hold_char_reg;
    logic        hold_last_reg;

    phase_t      phase_reg,   phase_next;
    logic [31:0] acc_reg,     acc_next;
    logic        minus_reg,   minus_next;
    logic        open_reg,    open_next;
    logic        pending_reg, pending_next;
    logic        started_reg, started_next;
    logic [15:0] crc_reg,     crc_next;

    logic        consume;
    logic        is_space;
    logic        is_digit;
    logic [31:0] digit_val;
    logic [15:0] crc_base;

    // a last item needs room downstream, others just update state
    assign consume  = hold_valid_reg && (!hold_last_reg || tally_ready);
    assign in_ready = !hold_valid_reg || consume;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            hold_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            hold_char_reg <= char_byte;
            hold_last_reg <= last_char;
        end
    end

    assign is_space  = (hold_char_reg == SPACE_CHAR);
    assign is_digit  = (hold_char_reg >= ZERO_CHAR) && (hold_char_reg <= NINE_CHAR);
    assign digit_val = {28'd0, hold_char_reg[3:0]};
    assign crc_base  = pending_reg ? crc_feed(crc_reg, SPACE_CHAR) : crc_reg;

    always_comb
    begin
        phase_next   = phase_reg;
        acc_next     = acc_reg;
        minus_next   = minus_reg;
        open_next    = open_reg;
        pending_next = pending_reg;
        started_next = started_reg;
        crc_next     = crc_reg;
        unique case (phase_reg)
            PH_LEAD:
            begin
                if (!is_space)
                begin
                    phase_next = PH_NUM;
                    priority if (hold_char_reg == MINUS_CHAR)
                    begin
                        minus_next = 1'b1;
                    end
                    else if (hold_char_reg == PLUS_CHAR)
                    begin
                        minus_next = minus_reg;
                    end
                    else if (is_digit)
                    begin
                        acc_next = digit_val;
                    end
                    else
                    begin
                        open_next = 1'b0;
                    end
                end
            end
            PH_NUM:
            begin
                if (is_space)
                begin
                    phase_next = PH_BODY;
                end
                else if (open_reg)
                begin
                    if (is_digit)
                    begin
                        // acc * 10 + digit, wraps mod 2^32
                        acc_next = {acc_reg[28:0], 3'b000} + {acc_reg[30:0], 1'b0} + digit_val;
                    end
                    else
                    begin
                        open_next = 1'b0;
                    end
                end
            end
            PH_BODY:
            begin
                if (is_space)
                begin
                    if (started_reg)
                    begin
                        pending_next = 1'b1;
                    end
                end
                else
                begin
                    crc_next     = crc_feed(crc_base, hold_char_reg);
                    pending_next = 1'b0;
                    started_next = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_LEAD;
            end
        endcase
    end

    assign tally_valid = hold_valid_reg && hold_last_reg;
    assign tally.acc   = acc_next;
    assign tally.minus = minus_next;
    assign tally.crc   = crc_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_LEAD;
            acc_reg     <= 32'd0;
            minus_reg   <= 1'b0;
            open_reg    <= 1'b1;
            pending_reg <= 1'b0;
            started_reg <= 1'b0;
            crc_reg     <= 16'd0;
        end
        else if (consume)
        begin
            if (hold_last_reg)
            begin
                // line done: back to line start
                phase_reg   <= PH_LEAD;
                acc_reg     <= 32'd0;
                minus_reg   <= 1'b0;
                open_reg    <= 1'b1;
                pending_reg <= 1'b0;
                started_reg <= 1'b0;
                crc_reg     <= 16'd0;
            end
            else
            begin
                phase_reg   <= phase_next;
                acc_reg     <= acc_next;
                minus_reg   <= minus_next;
                open_reg    <= open_next;
                pending_reg <= pending_next;
                started_reg <= started_next;
                crc_reg     <= crc_next;
            end
        end
    end

    a_owed_space_needs_payload: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg |-> started_reg)
        else $error("space owed before any payload byte");

    a_no_crc_before_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_BODY) |-> (crc_reg == 16'd0 && !started_reg && !pending_reg))
        else $error("crc touched before payload phase");

    a_lead_is_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_LEAD) |-> (acc_reg == 32'd0 && !minus_reg && open_reg))
        else $error("number state dirty before first token");

    a_line_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (consume && hold_last_reg) |=> (phase_reg == PH_LEAD && crc_reg == 16'd0))
        else $error("state not cleared after line end");

endmodule

`default_nettype wire

FILE: rtl/tfcc_result.sv
`default_nettype none

module tfcc_result (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               tally_valid,
    output logic                    tally_ready,
    input  wire tfcc_pkg::tally_t   tally,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    crc_ok,
    output logic [15:0]             computed_crc,
    output logic [31:0]             received_value
);
    import tfcc_pkg::*;

    logic        mid_valid_reg;
    tally_t      mid_reg;
    logic        out_valid_reg;
    logic        ok_reg;
    logic [15:0] crc_out_reg;
    logic [31:0] value_out_reg;

    logic        out_room;
    logic        mid_move;
    logic [31:0] value_next;
    logic        ok_next;

    assign out_room    = !out_valid_reg || out_ready;
    assign mid_move    = mid_valid_reg && out_room;
    assign tally_ready = !mid_valid_reg || out_room;

    assign value_next = mid_reg.minus ? (32'd0 - mid_reg.acc) : mid_reg.acc;
    assign ok_next    = (value_next == {16'd0, mid_reg.crc});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (tally_ready)
            begin
                mid_valid_reg <= tally_valid;
            end
            if (out_room)
            begin
                out_valid_reg <= mid_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tally_valid && tally_ready)
        begin
            mid_reg <= tally;
        end
        if (mid_move)
        begin
            value_out_reg <= value_next;
            crc_out_reg   <= mid_reg.crc;
            ok_reg        <= ok_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign crc_ok         = ok_reg;
    assign computed_crc   = crc_out_reg;
    assign received_value = value_out_reg;

    a_ok_matches_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (ok_reg == (value_out_reg == {16'd0, crc_out_reg})))
        else $error("crc_ok disagrees with reported fields");

    a_tally_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (tally_valid && tally_ready) |=> mid_valid_reg)
        else $error("line totals dropped");

    a_mid_held_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (mid_valid_reg && !out_room) |=> (mid_valid_reg && $stable(mid_reg)))
        else $error("pending totals lost while output stalled");

endmodule

`default_nettype wire

FILE: rtl/text_frame_crc16_checker_core.sv
// Throughput: one character per cycle, except that a line's last character waits
// for room in the totals register; the per-character CRC (two bytes when a
// separating space is owed) and the decimal update are computed combinationally.
// Pipeline: input register, parse/state stage, totals register, output register.
// Reset (rst_n, async, active low) empties the pipeline and returns to line start.
`default_nettype none

module text_frame_crc16_checker_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  char_byte,
    input  wire logic        last_char,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             crc_ok,
    output logic [15:0]      computed_crc,
    output logic [31:0]      received_value
);
    import tfcc_pkg::*;

    logic   tally_valid;
    logic   tally_ready;
    tally_t tally;

    tfcc_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .char_byte   (char_byte),
        .last_char   (last_char),
        .tally_valid (tally_valid),
        .tally_ready (tally_ready),
        .tally       (tally)
    );

    tfcc_result u_result (
        .clk            (clk),
        .rst_n          (rst_n),
        .tally_valid    (tally_valid),
        .tally_ready    (tally_ready),
        .tally          (tally),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .crc_ok         (crc_ok),
        .computed_crc   (computed_crc),
        .received_value (received_value)
    );

endmodule

`default_nettype wire

FILE: test/tb.sv
`timescale 1ns / 100ps

module tb;
    import tfcc_pkg::*;

    localparam int ITEM_TARGET  = 1650;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int IDLE_PCT     = 27;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int QUIET_FROM   = 700;
    localparam int QUIET_TO     = 1000;
    localparam int DRAIN_CYCLES = 10;
    localparam int MAX_SHOWN    = 10;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } char_item_t;

    typedef struct {
        logic        ok;
        logic [15:0] crc;
        logic [31:0] num;
    } line_verdict_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  char_byte = 8'h00;
    logic        last_char = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        crc_ok;
    logic [15:0] computed_crc;
    logic [31:0] received_value;

    char_item_t    char_q[$];       // characters waiting to be offered
    line_verdict_t verdict_q[$];    // expected per-line results, oldest first
    logic [7:0]    line_buf[$];     // line under construction

    // line parser state
    phase_t      ph;
    logic [31:0] acc;
    logic        neg;
    logic        digits_open;
    logic        owe_space;
    logic        body_started;
    logic [15:0] run_crc;

    int            taken_cnt = 0;
    int            mismatches = 0;
    int            cycles = 0;
    int            hold_left = 0;
    logic          hold_done = 1'b0;
    logic          quiet;
    logic          in_take;
    line_verdict_t want;

    text_frame_crc16_checker_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .char_byte      (char_byte),
        .last_char      (last_char),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .crc_ok         (crc_ok),
        .computed_crc   (computed_crc),
        .received_value (received_value)
    );

    always #2 clk = ~clk;

    assign quiet = (taken_cnt >= QUIET_FROM) && (taken_cnt < QUIET_TO);

    function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] d);
        logic fb;
        for (int k = 0; k < 8; k++)
        begin
            fb = c[15] ^ d[7];
            c  = c << 1;
            d  = d << 1;
            if (fb)
            begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    task automatic clear_line();
        ph           = PH_LEAD;
        acc          = '0;
        neg          = 1'b0;
        digits_open  = 1'b1;
        owe_space    = 1'b0;
        body_started = 1'b0;
        run_crc      = '0;
    endtask

    task automatic parse_char(input logic [7:0] c, input logic last);
        logic          sp;
        logic          dig;
        logic [31:0]   val;
        line_verdict_t v;
        sp  = (c == SPACE_CHAR);
        dig = (c >= ZERO_CHAR) && (c <= NINE_CHAR);
        case (ph)
            PH_LEAD:
            begin
                if (!sp)
                begin
                    ph = PH_NUM;
                    if (c == MINUS_CHAR)
                    begin
                        neg = 1'b1;
                    end
                    else if (c != PLUS_CHAR)
                    begin
                        if (dig)
                        begin
                            acc = 32'(c - ZERO_CHAR);
                        end
                        else
                        begin
                            digits_open = 1'b0;
                        end
                    end
                end
            end
            PH_NUM:
            begin
                if (sp)
                begin
                    ph = PH_BODY;
                end
                else if (digits_open)
                begin
                    if (dig)
                    begin
                        acc = acc * 32'd10 + 32'(c - ZERO_CHAR);
                    end
                    else
                    begin
                        digits_open = 1'b0;
                    end
                end
            end
            default:
            begin
                if (sp)
                begin
                    if (body_started)
                    begin
                        owe_space = 1'b1;
                    end
                end
                else
                begin
                    // words are rejoined by exactly one space
                    if (owe_space)
                    begin
                        run_crc   = crc_step(run_crc, SPACE_CHAR);
                        owe_space = 1'b0;
                    end
                    run_crc      = crc_step(run_crc, c);
                    body_started = 1'b1;
                end
            end
        endcase
        if (last)
        begin
            val   = neg ? (32'd0 - acc) : acc;
            v.ok  = (val == {16'h0000, run_crc});
            v.crc = run_crc;
            v.num = val;
            verdict_q.push_back(v);
            clear_line();
        end
    endtask

    task automatic push_line();
        foreach (line_buf[i])
        begin
            char_q.push_back('{line_buf[i], i == line_buf.size() - 1});
        end
        line_buf.delete();
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            line_buf.push_back(s[i]);
        end
    endtask

    task automatic push_decimal(input longint unsigned v);
        logic [7:0] dg[$];
        do
        begin
            dg.push_front(ZERO_CHAR + 8'(v % 10));
            v = v / 10;
        end
        while (v != 0);
        foreach (dg[i])
        begin
            line_buf.push_back(dg[i]);
        end
    endtask

    function automatic logic [7:0] word_char();
        logic [7:0] c;
        if ($urandom_range(9) == 0)
        begin
            c = 8'($urandom_range(255));
            if (c == SPACE_CHAR)
            begin
                c = 8'h7F;
            end
        end
        else
        begin
            c = 8'($urandom_range(8'h7E, 8'h21));
        end
        return c;
    endfunction

    function automatic logic [7:0] noise_char();
        int r;
        r = $urandom_range(99);
        if (r < 30)
        begin
            return SPACE_CHAR;
        end
        else if (r < 50)
        begin
            return ZERO_CHAR + 8'($urandom_range(9));
        end
        else if (r < 55)
        begin
            return r[0] ? MINUS_CHAR : PLUS_CHAR;
        end
        return 8'($urandom_range(255));
    endfunction

    // line whose leading number is the CRC of its words, unless spoiled
    task automatic gen_framed(input logic spoil);
        logic [7:0]        tail[$];
        logic [7:0]        payload[$];
        logic [7:0]        c8;
        logic [15:0]       c;
        longint unsigned   v;
        int                nw;
        nw = $urandom_range(4);
        for (int w = 0; w < nw; w++)
        begin
            repeat ($urandom_range(3, 1)) tail.push_back(SPACE_CHAR);
            if (w != 0)
            begin
                payload.push_back(SPACE_CHAR);
            end
            repeat ($urandom_range(6, 1))
            begin
                c8 = word_char();
                tail.push_back(c8);
                payload.push_back(c8);
            end
        end
        repeat ($urandom_range(2)) tail.push_back(SPACE_CHAR);
        c = '0;
        foreach (payload[i])
        begin
            c = crc_step(c, payload[i]);
        end
        v = c;
        if ($urandom_range(7) == 0)
        begin
            v = v + 64'h1_0000_0000;    // wraps back to the same value
        end
        if (spoil)
        begin
            v = v + $urandom_range(9, 1);
        end
        repeat ($urandom_range(2)) line_buf.push_back(SPACE_CHAR);
        if ($urandom_range(5) == 0)
        begin
            line_buf.push_back(PLUS_CHAR);
        end
        push_decimal(v);
        if ($urandom_range(7) == 0)
        begin
            line_buf.push_back(8'h3B);  // trailing junk in the token is ignored
        end
        foreach (tail[i])
        begin
            line_buf.push_back(tail[i]);
        end
        push_line();
    endtask

    task automatic gen_noise();
        if ($urandom_range(1))
        begin
            repeat ($urandom_range(2)) line_buf.push_back(SPACE_CHAR);
            case ($urandom_range(3))
                0: line_buf.push_back(MINUS_CHAR);
                1: line_buf.push_back(PLUS_CHAR);
                default: ;
            endcase
            repeat ($urandom_range(12, 1)) line_buf.push_back(ZERO_CHAR + 8'($urandom_range(9)));
        end
        repeat ($urandom_range(16, 1)) line_buf.push_back(noise_char());
        push_line();
    endtask

    // sender
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            in_take = in_valid && in_ready;
            if (in_take)
            begin
                parse_char(char_byte, last_char);
                void'(char_q.pop_front());
                taken_cnt <= taken_cnt + 1;
            end
            if (!in_valid || in_take)
            begin
                if (char_q.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT))
                begin
                    in_valid  <= 1'b1;
                    char_byte <= char_q[0].ch;
                    last_char <= char_q[0].last;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off so the block backs up into its input
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
            end
            else if (!hold_done && taken_cnt >= HOLD_AT)
            begin
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
            end
        end
    end

    // receiver and checker
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (verdict_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                    begin
                        $display("tb: unexpected result crc_ok=%0d crc=%h value=%h",
                                 crc_ok, computed_crc, received_value);
                    end
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (crc_ok !== want.ok || computed_crc !== want.crc ||
                        received_value !== want.num)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_SHOWN)
                        begin
                            $display("tb: mismatch exp ok=%0d crc=%h value=%h got ok=%0d crc=%h value=%h",
                                     want.ok, want.crc, want.num,
                                     crc_ok, computed_crc, received_value);
                        end
                    end
                end
            end
            out_ready <= (hold_left == 0) && (quiet || $urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        clear_line();

        // directed lines
        push_text("0");
        push_line();
        push_text(" ");
        push_line();
        push_text("-");
        push_line();
        push_text("+12x9 a\tb ");
        push_line();
        push_text("-7 ");
        line_buf.push_back(8'hFF);
        line_buf.push_back(8'h00);
        push_text(" ");
        line_buf.push_back(8'h80);
        push_line();
        push_text(" x 1");
        push_line();
        gen_framed(1'b0);

        while (char_q.size() < ITEM_TARGET)
        begin
            if ($urandom_range(99) < 65)
            begin
                gen_framed($urandom_range(9) == 0);
            end
            else
            begin
                gen_noise();
            end
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (char_q.size() != 0 || in_valid)
        begin
            @(posedge clk);
        end
        while (verdict_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && verdict_q.size() == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
